/* sv/bfr_pkg.sv */
package bfr_pkg;

  localparam int unsigned MAX_WIDTH     = 1024;
  localparam int unsigned RADIUS        = 6;
  localparam int unsigned WEIGHT_BITS   = 16;
  localparam int unsigned SIGMA_S       = 8;
  localparam int unsigned SIGMA_R       = 60;
  localparam int unsigned SPAN          = 2 * RADIUS + 1;
  localparam int unsigned NUM_TAPS      = SPAN * SPAN;
  localparam int unsigned STORE_DEPTH   = (2 * RADIUS + 2) * MAX_WIDTH;
  localparam int unsigned ADDR_W        = $clog2(STORE_DEPTH);
  localparam int unsigned RANGE_ENTRIES = 256;
  localparam int unsigned DIV_STEPS     = 9;

  localparam logic [7:0] CFG_FRAME_WIDTH  = 8'd0;
  localparam logic [7:0] CFG_FRAME_HEIGHT = 8'd1;

  typedef struct packed {
    logic       kind;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic [7:0] alpha_in;
  } bfr_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       frame_end;
  } bfr_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTRE,
    ST_SETUP,
    ST_TAPS,
    ST_FLUSH,
    ST_DIV_LOAD,
    ST_DIV,
    ST_EMIT
  } bfr_state_e;

  typedef struct packed {
    logic accept;
    logic centre_rd;
    logic setup_step;
    logic centre_cap;
    logic tap_issue;
    logic div_start;
    logic div_step;
    logic emit;
  } bfr_cmd_t;

  typedef struct packed {
    logic need_filter;
    logic pipe_busy;
    logic out_free;
  } bfr_sts_t;

  typedef logic [WEIGHT_BITS-1:0] weight_t;
  typedef weight_t spat_rom_t [NUM_TAPS];
  typedef weight_t range_rom_t [RANGE_ENTRIES];

  // shift and subtract, truncating
  function automatic longint unsigned div_u64(longint unsigned num, longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Q0.16 of exp(-p/q), alternating series in Q.32, evaluated at elaboration
  function automatic weight_t exp_weight(longint unsigned p, longint unsigned q);
    longint          sum;
    longint unsigned term;
    longint unsigned v;
    sum  = 0;
    term = 64'd1 << 32;
    for (int k = 0; k < 400 && term != 0; k++) begin
      if ((k & 1) != 0) sum = sum - longint'(term);
      else sum = sum + longint'(term);
      term = div_u64(term * p, q * longint'(k + 1));
    end
    if (sum < 0) sum = 0;
    v = (longint'(sum) + (64'd1 << (31 - WEIGHT_BITS))) >> (32 - WEIGHT_BITS);
    if (v > ((64'd1 << WEIGHT_BITS) - 1)) v = (64'd1 << WEIGHT_BITS) - 1;
    return v[WEIGHT_BITS-1:0];
  endfunction

  function automatic spat_rom_t build_spatial();
    spat_rom_t rom;
    longint    ddy;
    longint    ddx;
    for (int dy = 0; dy < SPAN; dy++) begin
      for (int dx = 0; dx < SPAN; dx++) begin
        ddy = longint'(dy) - longint'(RADIUS);
        ddx = longint'(dx) - longint'(RADIUS);
        rom[dy * SPAN + dx] = exp_weight(ddy * ddy + ddx * ddx, 2 * SIGMA_S * SIGMA_S);
      end
    end
    return rom;
  endfunction

  function automatic range_rom_t build_range();
    range_rom_t rom;
    for (int i = 0; i < RANGE_ENTRIES; i++) begin
      rom[i] = exp_weight(longint'(i) * longint'(i), 2 * SIGMA_R * SIGMA_R);
    end
    return rom;
  endfunction

  localparam spat_rom_t  SPATIAL_ROM = build_spatial();
  localparam range_rom_t RANGE_ROM   = build_range();

endpackage

/* sv/bilateral_filter_rgba_top.sv */
// 13x13 bilateral filter over an RGBA raster stream.
// Input channel (in_valid_i/in_ready_o/in_data_i): one pixel or drain item per
// beat, in raster order. Output pixel k comes out after input beat k+6*width+6
// has been taken; drain beats push out the tail of the frame. A drain beat
// while pixels are still due is taken and dropped; a pixel beat once the frame
// is complete acts as a drain.
// Output channel (out_valid_o/out_ready_i/out_data_o): one filtered pixel per
// beat, frame_end set on the last pixel of the frame.
// Config channel (cfg_*): index 0 frame width, index 1 frame height; always
// ready, written between frames; a write restarts the frame position.
// Timing: after a beat that yields no pixel the next beat can be taken in the
// following cycle. A beat that yields a pixel is accepted, then goes through
// centre read, row walk, 169 taps through the single line store read port,
// weight pipeline drain, a divider load and a restoring divide for each
// channel in parallel, then the load of the output register; the pixel shows
// in the cycle after that load, when the next beat is taken. That load waits
// while the register still holds a beat the receiver has not taken.
// Reset: width and height 64, frame position zero. The line store is not
// cleared; every read hits a location written earlier in the frame.
module bilateral_filter_rgba_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bfr_pkg::bfr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output bfr_pkg::bfr_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);
  import bfr_pkg::*;

  bfr_cmd_t cmd;
  bfr_sts_t sts;

  bfr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  bfr_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

/* sv/bfr_ram.sv */
module bfr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* sv/bfr_div.sv */
module bfr_div (
  input  logic        clk_i,
  input  logic        start_i,
  input  logic        step_i,
  input  logic [33:0] num_i,
  input  logic [24:0] den_i,
  output logic [8:0]  quot_o
);

  logic [33:0] rem_q, rem_d;
  logic [32:0] dsh_q, dsh_d;
  logic [8:0]  quot_q, quot_d;
  logic        ge;

  assign ge = rem_q >= {1'b0, dsh_q};

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    if (start_i) begin
      rem_d  = num_i;
      dsh_d  = {den_i, 8'd0};
      quot_d = '0;
    end else if (step_i) begin
      if (ge) rem_d = rem_q - {1'b0, dsh_q};
      dsh_d  = dsh_q >> 1;
      quot_d = {quot_q[7:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign quot_o = quot_q;

endmodule

/* sv/bfr_ctrl.sv */
module bfr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  bfr_pkg::bfr_sts_t sts_i,
  output bfr_pkg::bfr_cmd_t cmd_o
);
  import bfr_pkg::*;

  bfr_state_e state_q, state_d;
  logic [7:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i && sts_i.need_filter) state_d = ST_CENTRE;
      ST_CENTRE:   state_d = ST_SETUP;
      ST_SETUP:    if (cnt_q == 8'(RADIUS - 1)) state_d = ST_TAPS;
      ST_TAPS:     if (cnt_q == 8'(NUM_TAPS - 1)) state_d = ST_FLUSH;
      ST_FLUSH:    if (!sts_i.pipe_busy) state_d = ST_DIV_LOAD;
      ST_DIV_LOAD: state_d = ST_DIV;
      ST_DIV:      if (cnt_q == 8'(DIV_STEPS - 1)) state_d = ST_EMIT;
      ST_EMIT:     if (sts_i.out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_CENTRE:   cmd_o.centre_rd = 1'b1;
      ST_SETUP: begin
        cmd_o.setup_step = 1'b1;
        cmd_o.centre_cap = (cnt_q == 8'd0);
      end
      ST_TAPS:     cmd_o.tap_issue = 1'b1;
      ST_DIV_LOAD: cmd_o.div_start = 1'b1;
      ST_DIV:      cmd_o.div_step = 1'b1;
      ST_EMIT:     cmd_o.emit = sts_i.out_free;
      default:     cmd_o = '0;
    endcase
  end

  assign cnt_d = (state_d != state_q) ? 8'd0 : cnt_q + 8'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_tap_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_TAPS |-> cnt_q < 8'(NUM_TAPS))
    else $error("tap counter ran past the window");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.accept, cmd_o.centre_rd, cmd_o.setup_step, cmd_o.tap_issue,
              cmd_o.div_start, cmd_o.div_step, cmd_o.emit}))
    else $error("more than one datapath command");

  a_tap_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> $past(state_q) == ST_FLUSH)
    else $error("division started without flushing the taps");

endmodule

/* sv/bfr_dp.sv */
module bfr_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bfr_pkg::bfr_in_t  in_data_i,
  output bfr_pkg::bfr_out_t out_data_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  bfr_pkg::bfr_cmd_t cmd_i,
  output bfr_pkg::bfr_sts_t sts_o
);
  import bfr_pkg::*;

  localparam logic [ADDR_W:0] DEPTH_X = (ADDR_W + 1)'(STORE_DEPTH);

  // configuration and frame position
  logic [10:0]       fw_q, fw_d;
  logic [15:0]       fh_q, fh_d;
  logic [16:0]       in_row_q, in_row_d;
  logic [9:0]        in_col_q, in_col_d;
  logic [15:0]       out_row_q, out_row_d;
  logic [9:0]        out_col_q, out_col_d;
  logic [13:0]       lead_q, lead_d;
  logic [ADDR_W-1:0] in_addr_q, in_addr_d;
  logic [ADDR_W-1:0] ybase_q, ybase_d;

  logic [10:0] w;
  logic [15:0] h;
  logic [13:0] thr;
  logic        pixel_phase, drain_skip, advance, cfg_wr, last, restart;
  logic [ADDR_W:0] ybase_inc;

  always_comb begin
    if (fw_q == 11'd0) w = 11'd1;
    else if (fw_q > 11'(MAX_WIDTH)) w = 11'(MAX_WIDTH);
    else w = fw_q;
    h = (fh_q == 16'd0) ? 16'd1 : fh_q;
  end

  assign thr         = {3'b0, w} * 14'(RADIUS) + 14'(RADIUS);
  assign pixel_phase = in_row_q < {1'b0, h};
  assign drain_skip  = pixel_phase && in_data_i.kind;
  assign advance     = cmd_i.accept && !drain_skip;
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i &&
                       (cfg_index_i == CFG_FRAME_WIDTH || cfg_index_i == CFG_FRAME_HEIGHT);
  assign last        = (out_row_q >= h - 16'd1) && ({1'b0, out_col_q} >= w - 11'd1);
  assign restart     = cfg_wr || (cmd_i.emit && last);
  assign ybase_inc   = {1'b0, ybase_q} + (ADDR_W + 1)'(w);

  always_comb begin
    fw_d      = fw_q;
    fh_d      = fh_q;
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    lead_d    = lead_q;
    in_addr_d = in_addr_q;
    ybase_d   = ybase_q;
    if (advance) begin
      in_addr_d = (in_addr_q == ADDR_W'(STORE_DEPTH - 1)) ? '0 : in_addr_q + 1'b1;
      if ({1'b0, in_col_q} + 11'd1 >= w) begin
        in_col_d = '0;
        in_row_d = in_row_q + 17'd1;
      end else begin
        in_col_d = in_col_q + 10'd1;
      end
      if (lead_q < thr) lead_d = lead_q + 14'd1;
    end
    if (cmd_i.emit) begin
      if ({1'b0, out_col_q} + 11'd1 >= w) begin
        out_col_d = '0;
        out_row_d = out_row_q + 16'd1;
        ybase_d   = (ybase_inc >= DEPTH_X) ? ADDR_W'(ybase_inc - DEPTH_X)
                                           : ybase_inc[ADDR_W-1:0];
      end else begin
        out_col_d = out_col_q + 10'd1;
      end
    end
    if (cfg_wr) begin
      if (cfg_index_i == CFG_FRAME_WIDTH) fw_d = cfg_data_i[10:0];
      else fh_d = cfg_data_i;
    end
    if (restart) begin
      in_row_d  = '0;
      in_col_d  = '0;
      out_row_d = '0;
      out_col_d = '0;
      lead_d    = '0;
      in_addr_d = '0;
      ybase_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q      <= 11'd64;
      fh_q      <= 16'd64;
      in_row_q  <= '0;
      in_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      lead_q    <= '0;
      in_addr_q <= '0;
      ybase_q   <= '0;
    end else begin
      fw_q      <= fw_d;
      fh_q      <= fh_d;
      in_row_q  <= in_row_d;
      in_col_q  <= in_col_d;
      out_row_q <= out_row_d;
      out_col_q <= out_col_d;
      lead_q    <= lead_d;
      in_addr_q <= in_addr_d;
      ybase_q   <= ybase_d;
    end
  end

  // window walk
  logic [ADDR_W-1:0] base_q, base_d;
  logic [15:0]       walk_q, walk_d;
  logic [3:0]        dxi_q, dxi_d, dyi_q, dyi_d;
  logic [7:0]        ti_q, ti_d;
  logic [ADDR_W:0]   base_dec, base_inc, tap_sum, centre_sum;
  logic signed [11:0] vx, wlast_s;
  logic signed [17:0] vr, hlast_s;
  logic [9:0]        sx;
  logic [ADDR_W-1:0] raddr, tap_addr, centre_addr;
  logic              re;
  logic [31:0]       rdata;

  assign base_dec = (base_q >= ADDR_W'(w)) ? {1'b0, base_q} - (ADDR_W + 1)'(w)
                                           : {1'b0, base_q} + DEPTH_X - (ADDR_W + 1)'(w);
  assign base_inc = {1'b0, base_q} + (ADDR_W + 1)'(w);
  assign vx       = $signed({2'b0, out_col_q}) + $signed({8'b0, dxi_q}) - 12'sd6;
  assign wlast_s  = $signed({1'b0, w}) - 12'sd1;
  assign vr       = $signed({2'b0, out_row_q}) + $signed({14'b0, dyi_q}) - 18'sd6;
  assign hlast_s  = $signed({2'b0, h}) - 18'sd1;

  always_comb begin
    if (vx < 12'sd0) sx = '0;
    else if (vx > wlast_s) sx = wlast_s[9:0];
    else sx = vx[9:0];
  end

  assign tap_sum     = {1'b0, base_q} + (ADDR_W + 1)'(sx);
  assign tap_addr    = (tap_sum >= DEPTH_X) ? ADDR_W'(tap_sum - DEPTH_X) : tap_sum[ADDR_W-1:0];
  assign centre_sum  = {1'b0, ybase_q} + (ADDR_W + 1)'(out_col_q);
  assign centre_addr = (centre_sum >= DEPTH_X) ? ADDR_W'(centre_sum - DEPTH_X)
                                               : centre_sum[ADDR_W-1:0];
  assign re          = cmd_i.centre_rd || cmd_i.tap_issue;
  assign raddr       = cmd_i.centre_rd ? centre_addr : tap_addr;

  always_comb begin
    base_d = base_q;
    walk_d = walk_q;
    dxi_d  = dxi_q;
    dyi_d  = dyi_q;
    ti_d   = ti_q;
    if (cmd_i.centre_rd) begin
      base_d = ybase_q;
      walk_d = out_row_q;
      dxi_d  = '0;
      dyi_d  = '0;
      ti_d   = '0;
    end else if (cmd_i.setup_step) begin
      if (walk_q != 16'd0) begin
        base_d = base_dec[ADDR_W-1:0];
        walk_d = walk_q - 16'd1;
      end
    end else if (cmd_i.tap_issue) begin
      ti_d = ti_q + 8'd1;
      if (dxi_q == 4'(SPAN - 1)) begin
        dxi_d = '0;
        dyi_d = dyi_q + 4'd1;
        if (vr >= 18'sd0 && vr < hlast_s) begin
          base_d = (base_inc >= DEPTH_X) ? ADDR_W'(base_inc - DEPTH_X)
                                         : base_inc[ADDR_W-1:0];
        end
      end else begin
        dxi_d = dxi_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    walk_q <= walk_d;
    dxi_q  <= dxi_d;
    dyi_q  <= dyi_d;
    ti_q   <= ti_d;
  end

  bfr_ram #(
    .WIDTH(32),
    .DEPTH(STORE_DEPTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (advance && pixel_phase),
    .waddr_i(in_addr_q),
    .wdata_i({in_data_i.alpha_in, in_data_i.blue_in, in_data_i.green_in, in_data_i.red_in}),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // weight pipeline
  logic        v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [7:0]  ti1_q, ti2_q, ti3_q, ti4_q;
  logic [31:0] centre_q;
  logic [7:0]  d0, d1, d2;
  weight_t     r0_q, r1_q, r2_q, r2b_q, m1_q, m2_q, wt_q;
  logic [23:0] px2_q, px3_q, px4_q, px5_q;
  logic [31:0] prod1, prod2, prod3;
  logic [31:0] acc_r_q, acc_g_q, acc_b_q;
  logic [23:0] wsum_q;
  logic [23:0] pr_r, pr_g, pr_b;

  function automatic logic [7:0] absdiff(logic [7:0] a, logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  assign d0    = absdiff(centre_q[7:0],   rdata[7:0]);
  assign d1    = absdiff(centre_q[15:8],  rdata[15:8]);
  assign d2    = absdiff(centre_q[23:16], rdata[23:16]);
  assign prod1 = {16'b0, r0_q} * {16'b0, r1_q};
  assign prod2 = {16'b0, m1_q} * {16'b0, r2b_q};
  assign prod3 = {16'b0, SPATIAL_ROM[ti4_q]} * {16'b0, m2_q};
  assign pr_r  = wt_q * {16'b0, px5_q[7:0]};
  assign pr_g  = wt_q * {16'b0, px5_q[15:8]};
  assign pr_b  = wt_q * {16'b0, px5_q[23:16]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.tap_issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.centre_cap) centre_q <= rdata;
    ti1_q <= ti_q;
    ti2_q <= ti1_q;
    r0_q  <= RANGE_ROM[d0];
    r1_q  <= RANGE_ROM[d1];
    r2_q  <= RANGE_ROM[d2];
    px2_q <= rdata[23:0];
    m1_q  <= prod1[31:16];
    r2b_q <= r2_q;
    px3_q <= px2_q;
    ti3_q <= ti2_q;
    m2_q  <= prod2[31:16];
    px4_q <= px3_q;
    ti4_q <= ti3_q;
    wt_q  <= prod3[31:16];
    px5_q <= px4_q;
    if (cmd_i.centre_rd) begin
      acc_r_q <= '0;
      acc_g_q <= '0;
      acc_b_q <= '0;
      wsum_q  <= '0;
    end else if (v5_q) begin
      acc_r_q <= acc_r_q + {8'b0, pr_r};
      acc_g_q <= acc_g_q + {8'b0, pr_g};
      acc_b_q <= acc_b_q + {8'b0, pr_b};
      wsum_q  <= wsum_q + {8'b0, wt_q};
    end
  end

  // per-channel rounding division
  logic [8:0] q_r, q_g, q_b;

  bfr_div u_div_r (
    .clk_i  (clk_i),
    .start_i(cmd_i.div_start),
    .step_i (cmd_i.div_step),
    .num_i  ({1'b0, acc_r_q, 1'b0} + {10'b0, wsum_q}),
    .den_i  ({wsum_q, 1'b0}),
    .quot_o (q_r)
  );

  bfr_div u_div_g (
    .clk_i  (clk_i),
    .start_i(cmd_i.div_start),
    .step_i (cmd_i.div_step),
    .num_i  ({1'b0, acc_g_q, 1'b0} + {10'b0, wsum_q}),
    .den_i  ({wsum_q, 1'b0}),
    .quot_o (q_g)
  );

  bfr_div u_div_b (
    .clk_i  (clk_i),
    .start_i(cmd_i.div_start),
    .step_i (cmd_i.div_step),
    .num_i  ({1'b0, acc_b_q, 1'b0} + {10'b0, wsum_q}),
    .den_i  ({wsum_q, 1'b0}),
    .quot_o (q_b)
  );

  // output register
  bfr_out_t out_q;
  logic     out_valid_q;
  logic     zero_w;

  assign zero_w = (wsum_q == 24'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.red_out   <= zero_w ? centre_q[7:0]   : (q_r[8] ? 8'hFF : q_r[7:0]);
      out_q.green_out <= zero_w ? centre_q[15:8]  : (q_g[8] ? 8'hFF : q_g[7:0]);
      out_q.blue_out  <= zero_w ? centre_q[23:16] : (q_b[8] ? 8'hFF : q_b[7:0]);
      out_q.alpha_out <= centre_q[31:24];
      out_q.frame_end <= last;
    end
  end

  assign out_data_o        = out_q;
  assign out_valid_o       = out_valid_q;
  assign sts_o.need_filter = !drain_skip && (lead_q >= thr);
  assign sts_o.pipe_busy   = v1_q || v2_q || v3_q || v4_q || v5_q;
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken beat");

  a_rd_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    re |-> raddr < ADDR_W'(STORE_DEPTH))
    else $error("line store read outside its depth");

  a_wr_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_addr_q < ADDR_W'(STORE_DEPTH) && ybase_q < ADDR_W'(STORE_DEPTH))
    else $error("line store pointer outside its depth");

  a_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tap_issue |-> dxi_q < 4'(SPAN) && dyi_q < 4'(SPAN))
    else $error("window walk out of range");

endmodule

/* tb/bilateral_filter_rgba_top_tb.sv */
module bilateral_filter_rgba_top_tb;
  import bfr_pkg::*;

  localparam int unsigned HALF_LAT = 250;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  bfr_in_t    in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  bfr_out_t   out_data_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  bilateral_filter_rgba_top i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [31:0]  px_store [STORE_DEPTH];
  weight_t      spat_w [NUM_TAPS];
  weight_t      rng_w [RANGE_ENTRIES];
  logic [10:0]  width_reg = 11'd64;
  logic [15:0]  height_reg = 16'd64;
  int unsigned  in_row, in_col, out_row, out_col;
  bfr_out_t     pending_px [$];
  int unsigned  n_errors = 0;
  int unsigned  idle_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  beats_sent = 0;

  function automatic weight_t gauss_q16(longint unsigned p, longint unsigned q);
    longint          acc;
    longint unsigned t;
    longint unsigned r;
    acc = 0;
    t = 64'd1 << 32;
    for (int k = 0; k < 400 && t != 0; k++) begin
      if (k % 2 == 1) acc -= longint'(t);
      else acc += longint'(t);
      t = t * p / (q * longint'(k + 1));
    end
    if (acc < 0) acc = 0;
    r = ($unsigned(acc) + (64'd1 << (31 - WEIGHT_BITS))) >> (32 - WEIGHT_BITS);
    if (r > 64'hFFFF) r = 64'hFFFF;
    return r[15:0];
  endfunction

  task automatic fill_weights();
    for (int dy = 0; dy < SPAN; dy++)
      for (int dx = 0; dx < SPAN; dx++)
        spat_w[dy * SPAN + dx] = gauss_q16((dy - RADIUS) * (dy - RADIUS) +
                                           (dx - RADIUS) * (dx - RADIUS),
                                           2 * SIGMA_S * SIGMA_S);
    for (int i = 0; i < RANGE_ENTRIES; i++)
      rng_w[i] = gauss_q16(i * i, 2 * SIGMA_R * SIGMA_R);
  endtask

  function automatic int unsigned act_width();
    if (width_reg == 0) return 1;
    return (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
  endfunction

  function automatic int unsigned act_height();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  function automatic int unsigned addr_of(int unsigned r, int unsigned c, int unsigned w);
    return (longint'(r) * w + c) % STORE_DEPTH;
  endfunction

  function automatic bfr_out_t filter_pixel(int unsigned y, int unsigned x,
                                            int unsigned w, int unsigned h);
    logic [31:0]     ctr;
    logic [31:0]     nb;
    longint unsigned sums [3];
    longint unsigned wsum;
    longint unsigned wr;
    longint unsigned wt;
    longint unsigned v;
    int              sy;
    int              sx;
    int              a;
    int              b;
    int unsigned     d [3];
    bfr_out_t        o;
    ctr = px_store[addr_of(y, x, w)];
    sums = '{0, 0, 0};
    wsum = 0;
    for (int dy = -int'(RADIUS); dy <= int'(RADIUS); dy++) begin
      sy = int'(y) + dy;
      if (sy < 0) sy = 0;
      if (sy > int'(h) - 1) sy = int'(h) - 1;
      for (int dx = -int'(RADIUS); dx <= int'(RADIUS); dx++) begin
        sx = int'(x) + dx;
        if (sx < 0) sx = 0;
        if (sx > int'(w) - 1) sx = int'(w) - 1;
        nb = px_store[addr_of(sy, sx, w)];
        for (int c = 0; c < 3; c++) begin
          a = ctr[8*c +: 8];
          b = nb[8*c +: 8];
          d[c] = (a > b) ? a - b : b - a;
        end
        wr = (longint'(rng_w[d[0]]) * rng_w[d[1]]) >> WEIGHT_BITS;
        wr = (wr * rng_w[d[2]]) >> WEIGHT_BITS;
        wt = (longint'(spat_w[(dy + RADIUS) * SPAN + dx + RADIUS]) * wr) >> WEIGHT_BITS;
        for (int c = 0; c < 3; c++) sums[c] += wt * nb[8*c +: 8];
        wsum += wt;
      end
    end
    for (int c = 0; c < 3; c++) begin
      if (wsum == 0) v = ctr[8*c +: 8];
      else v = (2 * sums[c] + wsum) / (2 * wsum);
      if (v > 255) v = 255;
      case (c)
        0: o.red_out = v[7:0];
        1: o.green_out = v[7:0];
        default: o.blue_out = v[7:0];
      endcase
    end
    o.alpha_out = ctr[31:24];
    o.frame_end = 1'b0;
    return o;
  endfunction

  task automatic predict_beat(bfr_in_t d);
    int unsigned     w;
    int unsigned     h;
    longint unsigned m;
    bfr_out_t        o;
    bit              last;
    w = act_width();
    h = act_height();
    if (in_row < h) begin
      if (d.kind) return;
      px_store[addr_of(in_row, in_col, w)] = {d.alpha_in, d.blue_in, d.green_in, d.red_in};
    end
    m = longint'(in_row) * w + in_col;
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (m < RADIUS * w + RADIUS) return;
    o = filter_pixel(out_row, out_col, w, h);
    last = (out_row >= h - 1) && (out_col >= w - 1);
    o.frame_end = last;
    pending_px.push_back(o);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (last) {in_row, in_col, out_row, out_col} = '0;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    bfr_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_px.size() == 0) begin
        $error("unexpected output beat %h", out_data_o);
        n_errors++;
      end else begin
        e = pending_px.pop_front();
        if (out_data_o.red_out !== e.red_out) begin
          $error("red_out exp %0d got %0d", e.red_out, out_data_o.red_out);
          n_errors++;
        end
        if (out_data_o.green_out !== e.green_out) begin
          $error("green_out exp %0d got %0d", e.green_out, out_data_o.green_out);
          n_errors++;
        end
        if (out_data_o.blue_out !== e.blue_out) begin
          $error("blue_out exp %0d got %0d", e.blue_out, out_data_o.blue_out);
          n_errors++;
        end
        if (out_data_o.alpha_out !== e.alpha_out) begin
          $error("alpha_out exp %0d got %0d", e.alpha_out, out_data_o.alpha_out);
          n_errors++;
        end
        if (out_data_o.frame_end !== e.frame_end) begin
          $error("frame_end exp %0d got %0d", e.frame_end, out_data_o.frame_end);
          n_errors++;
        end
      end
    end
  end

  task automatic send_beat(bfr_in_t d);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    predict_beat(d);
    beats_sent++;
    @(negedge clk_i);
  endtask

  function automatic bfr_in_t rand_px(bit k);
    bfr_in_t d;
    d = bfr_in_t'($urandom);
    d.kind = k;
    return d;
  endfunction

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_px.size() != 0) @(negedge clk_i);
    repeat (HALF_LAT) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_FRAME_WIDTH) width_reg = val[10:0];
    else if (idx == CFG_FRAME_HEIGHT) height_reg = val;
    if (idx == CFG_FRAME_WIDTH || idx == CFG_FRAME_HEIGHT)
      {in_row, in_col, out_row, out_col} = '0;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // full frame, with optional noise beats and an early cut
  task automatic run_frame(int unsigned w, int unsigned h, bit cut);
    int unsigned total;
    int unsigned stop_at;
    write_reg(CFG_FRAME_WIDTH, 16'(w));
    write_reg(CFG_FRAME_HEIGHT, 16'(h));
    total = act_width() * act_height() + RADIUS * act_width() + RADIUS;
    stop_at = cut ? $urandom_range(total - 1, 1) : total;
    for (int i = 0; i < stop_at; i++) begin
      if (i < act_width() * act_height()) begin
        if ($urandom_range(9) == 0) send_beat(rand_px(1'b1));
        send_beat(rand_px(1'b0));
      end else begin
        send_beat(rand_px($urandom_range(4) != 0));
      end
    end
  endtask

  task automatic test_directed();
    bfr_in_t d;
    idle_pct = 0;
    stall_pct = 0;
    write_reg(CFG_FRAME_WIDTH, 16'd0);
    write_reg(CFG_FRAME_HEIGHT, 16'd0);
    send_beat(rand_px(1'b1));
    d = '{kind: 1'b0, red_in: 8'hFF, green_in: 8'h00, blue_in: 8'hFF, alpha_in: 8'h00};
    send_beat(d);
    send_beat(rand_px(1'b1));
    for (int i = 0; i < 11; i++) send_beat(rand_px(i % 2 == 0));
    write_reg(CFG_FRAME_WIDTH, 16'd2);
    write_reg(CFG_FRAME_HEIGHT, 16'd1);
    d = '{kind: 1'b0, red_in: 8'h00, green_in: 8'hFF, blue_in: 8'h00, alpha_in: 8'hFF};
    send_beat(d);
    d = '{kind: 1'b0, red_in: 8'hFF, green_in: 8'hFF, blue_in: 8'hFF, alpha_in: 8'hFF};
    send_beat(d);
    for (int i = 0; i < 8; i++) send_beat(rand_px(1'b1));
    write_reg(8'd2, 16'd5);
    write_reg(8'hFF, 16'hFFFF);
    for (int i = 0; i < 3; i++) send_beat(rand_px(1'b1));
  endtask

  task automatic test_extreme_regs();
    write_reg(CFG_FRAME_WIDTH, 16'h07FF);
    write_reg(CFG_FRAME_HEIGHT, 16'd1);
    for (int i = 0; i < 16; i++) send_beat(rand_px(1'b0));
    write_reg(CFG_FRAME_WIDTH, 16'd1);
    write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
    for (int i = 0; i < 30; i++) send_beat(rand_px(1'b0));
    write_reg(CFG_FRAME_WIDTH, 16'd1024);
    write_reg(CFG_FRAME_HEIGHT, 16'd1);
    for (int i = 0; i < 8; i++) send_beat(rand_px(1'b0));
  endtask

  task automatic test_pause();
    write_reg(CFG_FRAME_WIDTH, 16'd3);
    write_reg(CFG_FRAME_HEIGHT, 16'd3);
    for (int i = 0; i < 27; i++) begin
      if (i == 26) begin
        in_valid_i <= 1'b0;
        while (pending_px.size() != 0) @(negedge clk_i);
      end
      send_beat(rand_px(i >= 9));
    end
  endtask

  task automatic test_random();
    int unsigned goal;
    int unsigned idle_set [4] = '{0, 45, 0, 26};
    int unsigned stall_set [4] = '{0, 0, 45, 26};
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_set[p];
      stall_pct = stall_set[p];
      goal = beats_sent + 60;
      while (beats_sent < goal)
        run_frame($urandom_range(7, 1), $urandom_range(5, 1), $urandom_range(5) == 0);
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    fill_weights();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_extreme_regs();
    test_pause();
    test_random();
    wait_drained();
    if (n_errors == 0 && pending_px.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("Verification failed");
    $finish;
  end

endmodule
